@@ design/amel_pkg.sv @@
`default_nettype none
package amel_pkg;

  localparam int MAX_VERTICES = 64;
  localparam int COL_W        = $clog2(MAX_VERTICES);
  localparam int VTX_W        = 7;
  localparam int EDGE_W       = 12;

  localparam logic [VTX_W-1:0]  ROW_MAX        = 7'd127;
  localparam logic [EDGE_W-1:0] EDGE_CNT_MAX   = 12'd4095;
  localparam logic [EDGE_W-1:0] EDGE_INDEX_TOP = 12'd2079;
  localparam logic [VTX_W-1:0]  VC_RESET       = 7'd64;
  localparam logic [EDGE_W-1:0] EC_RESET       = 12'd2080;

  // Register index decoded from the byte address.
  localparam logic REG_VERTEX_COUNT  = 1'b0;
  localparam logic REG_EDGE_CAPACITY = 1'b1;

  typedef enum logic {
    ST_IDLE,
    ST_SCAN
  } state_t;

  typedef struct packed {
    logic load;
    logic emit;
  } cmd_t;

  typedef struct packed {
    logic mask_empty;
    logic out_free;
  } status_t;

endpackage
`default_nettype wire

@@ design/amel_ctrl.sv @@
`default_nettype none
module amel_ctrl (
  input  wire               clk,
  input  wire               rst_n,
  input  wire               in_tvalid,
  output logic              in_tready,
  input  amel_pkg::status_t status,
  output amel_pkg::cmd_t    cmd
);

  amel_pkg::state_t state_r;
  amel_pkg::state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= amel_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      amel_pkg::ST_IDLE: begin
        if (in_tvalid) begin
          state_nxt = amel_pkg::ST_SCAN;
        end
      end
      amel_pkg::ST_SCAN: begin
        if (status.mask_empty) begin
          state_nxt = amel_pkg::ST_IDLE;
        end
      end
      default: state_nxt = amel_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    in_tready = 1'b0;
    cmd.load  = 1'b0;
    cmd.emit  = 1'b0;
    case (state_r)
      amel_pkg::ST_IDLE: begin
        in_tready = 1'b1;
        cmd.load  = in_tvalid;
      end
      amel_pkg::ST_SCAN: begin
        cmd.emit = !status.mask_empty && status.out_free;
      end
      default: begin
        in_tready = 1'b0;
      end
    endcase
  end

endmodule
`default_nettype wire

@@ design/amel_dp.sv @@
`default_nettype none
module amel_dp (
  input  wire                                clk,
  input  wire                                rst_n,
  input  amel_pkg::cmd_t                     cmd,
  output amel_pkg::status_t                  status,
  input  wire [amel_pkg::MAX_VERTICES-1:0]   row_bits,
  input  wire                                first_row,
  input  wire [amel_pkg::VTX_W-1:0]          vertex_count,
  input  wire [amel_pkg::EDGE_W-1:0]         edge_capacity,
  output logic                               out_valid,
  input  wire                                out_ready,
  output logic [amel_pkg::VTX_W-1:0]         from_vertex,
  output logic [amel_pkg::VTX_W-1:0]         to_vertex,
  output logic [amel_pkg::EDGE_W-1:0]        edge_index,
  output logic                               overflow,
  output logic                               row_last
);

  localparam int NV = amel_pkg::MAX_VERTICES;

  logic [NV-1:0]                 mask_r, mask_nxt;
  logic [amel_pkg::VTX_W-1:0]    row_r, row_nxt;
  logic [amel_pkg::VTX_W-1:0]    row_cnt_r, row_cnt_nxt;
  logic [amel_pkg::EDGE_W-1:0]   edge_cnt_r, edge_cnt_nxt;
  logic                          out_valid_r, out_valid_nxt;
  logic [amel_pkg::VTX_W-1:0]    from_r, to_r;
  logic [amel_pkg::EDGE_W-1:0]   index_r;
  logic                          ovf_r, last_r;

  logic [amel_pkg::VTX_W-1:0]    n_eff;
  logic [amel_pkg::VTX_W-1:0]    row_start;
  logic [NV-1:0]                 lo_mask, hi_mask;
  logic [NV-1:0]                 low_hot, remaining;
  logic [amel_pkg::COL_W-1:0]    col;

  always_comb begin
    if (vertex_count > amel_pkg::VTX_W'(NV)) begin
      n_eff = amel_pkg::VTX_W'(NV);
    end else begin
      n_eff = vertex_count;
    end
    row_start = first_row ? '0 : row_cnt_r;
    // Columns below the vertex count, and on or above the diagonal.
    if (n_eff >= amel_pkg::VTX_W'(NV)) begin
      lo_mask = '1;
    end else begin
      lo_mask = (NV'(1) << n_eff[amel_pkg::COL_W-1:0]) - NV'(1);
    end
    if (row_start >= amel_pkg::VTX_W'(NV)) begin
      hi_mask = '0;
    end else begin
      hi_mask = ~((NV'(1) << row_start[amel_pkg::COL_W-1:0]) - NV'(1));
    end
  end

  // Lowest set bit of the pending mask picks the next column.
  always_comb begin
    low_hot   = mask_r & (~mask_r + NV'(1));
    remaining = mask_r & ~low_hot;
    col       = '0;
    for (int i = 0; i < NV; i++) begin
      if (low_hot[i]) begin
        col = col | amel_pkg::COL_W'(i);
      end
    end
  end

  always_comb begin
    mask_nxt      = mask_r;
    row_nxt       = row_r;
    row_cnt_nxt   = row_cnt_r;
    edge_cnt_nxt  = edge_cnt_r;
    out_valid_nxt = out_valid_r;
    if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
    if (cmd.load) begin
      mask_nxt = row_bits & lo_mask & hi_mask;
      row_nxt  = row_start;
      if (row_start < amel_pkg::ROW_MAX) begin
        row_cnt_nxt = row_start + amel_pkg::VTX_W'(1);
      end else begin
        row_cnt_nxt = amel_pkg::ROW_MAX;
      end
      if (first_row) begin
        edge_cnt_nxt = '0;
      end
    end else if (cmd.emit) begin
      mask_nxt      = remaining;
      out_valid_nxt = 1'b1;
      if (edge_cnt_r < amel_pkg::EDGE_CNT_MAX) begin
        edge_cnt_nxt = edge_cnt_r + amel_pkg::EDGE_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mask_r      <= '0;
      row_cnt_r   <= '0;
      edge_cnt_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      mask_r      <= mask_nxt;
      row_cnt_r   <= row_cnt_nxt;
      edge_cnt_r  <= edge_cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    row_r <= row_nxt;
    if (cmd.emit) begin
      from_r  <= row_r + amel_pkg::VTX_W'(1);
      to_r    <= amel_pkg::VTX_W'(col) + amel_pkg::VTX_W'(1);
      index_r <= (edge_cnt_r > amel_pkg::EDGE_INDEX_TOP) ? amel_pkg::EDGE_INDEX_TOP
                                                          : edge_cnt_r;
      ovf_r   <= (edge_cnt_r >= edge_capacity);
      last_r  <= (remaining == '0);
    end
  end

  assign status.mask_empty = (mask_r == '0);
  assign status.out_free   = !out_valid_r || out_ready;

  assign out_valid   = out_valid_r;
  assign from_vertex = from_r;
  assign to_vertex   = to_r;
  assign edge_index  = index_r;
  assign overflow    = ovf_r;
  assign row_last    = last_r;

endmodule
`default_nettype wire

@@ design/adjacency_matrix_to_edge_list.sv @@
// Adjacency matrix to edge list converter.
// Input channel: one word per matrix row. in_tdata carries the 64 row bits,
// in_tuser is the first-row flag that restarts the row and edge counters.
// Output channel: one word per edge on or above the diagonal, in ascending
// column order. out_tlast marks the last edge of a row and out_tuser flags
// an edge whose position reached the edge capacity. A row with no edges
// produces no word.
// Timing: a row is taken while the controller is idle; the scan state then
// registers its edges into the output word, one per cycle while the
// receiver keeps up. The pace is set by the priority encoder that pulls one
// set bit per cycle out of the pending row mask whenever the output is free.
// The output register decouples the sides: the next row is accepted while
// the last edge of the previous one still waits. A stalled receiver holds
// the output word and pauses the scan.
// Reset: vertex_count returns to 64, edge_capacity to 2080, counters to 0.
// Configuration over APB: vertex_count at 0x0, edge_capacity at 0x4.
`default_nettype none
module adjacency_matrix_to_edge_list (
  input  wire        clk,
  input  wire        rst_n,
  input  wire        in_tvalid,
  output logic       in_tready,
  input  wire [63:0] in_tdata,   // [63:0] row_bits
  input  wire        in_tuser,   // [0] first_row
  output logic       out_tvalid,
  input  wire        out_tready,
  output logic [31:0] out_tdata, // [6:0] from_vertex, [13:7] to_vertex,
                                 // [25:14] edge_index, [31:26] zero
  output logic       out_tlast,
  output logic       out_tuser,  // [0] overflow
  input  wire        cfg_psel,
  input  wire        cfg_penable,
  input  wire        cfg_pwrite,
  input  wire [2:0]  cfg_paddr,
  input  wire [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic       cfg_pready
);

  logic [amel_pkg::VTX_W-1:0]  vc_r, vc_nxt;
  logic [amel_pkg::EDGE_W-1:0] ec_r, ec_nxt;
  logic                        cfg_wr;
  logic                        reg_sel;

  amel_pkg::cmd_t    cmd;
  amel_pkg::status_t status;

  logic [amel_pkg::VTX_W-1:0]  from_vertex, to_vertex;
  logic [amel_pkg::EDGE_W-1:0] edge_index;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign reg_sel    = cfg_paddr[2];

  always_comb begin
    vc_nxt = vc_r;
    ec_nxt = ec_r;
    if (cfg_wr) begin
      case (reg_sel)
        amel_pkg::REG_VERTEX_COUNT:  vc_nxt = cfg_pwdata[amel_pkg::VTX_W-1:0];
        amel_pkg::REG_EDGE_CAPACITY: ec_nxt = cfg_pwdata[amel_pkg::EDGE_W-1:0];
        default: vc_nxt = vc_r;
      endcase
    end
  end

  always_comb begin
    case (reg_sel)
      amel_pkg::REG_VERTEX_COUNT:  cfg_prdata = 32'(vc_r);
      amel_pkg::REG_EDGE_CAPACITY: cfg_prdata = 32'(ec_r);
      default: cfg_prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vc_r <= amel_pkg::VC_RESET;
      ec_r <= amel_pkg::EC_RESET;
    end else begin
      vc_r <= vc_nxt;
      ec_r <= ec_nxt;
    end
  end

  amel_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .status    (status),
    .cmd       (cmd)
  );

  amel_dp u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (cmd),
    .status        (status),
    .row_bits      (in_tdata),
    .first_row     (in_tuser),
    .vertex_count  (vc_r),
    .edge_capacity (ec_r),
    .out_valid     (out_tvalid),
    .out_ready     (out_tready),
    .from_vertex   (from_vertex),
    .to_vertex     (to_vertex),
    .edge_index    (edge_index),
    .overflow      (out_tuser),
    .row_last      (out_tlast)
  );

  assign out_tdata = {6'd0, edge_index, to_vertex, from_vertex};

endmodule
`default_nettype wire

@@ design/amel_checker.sv @@
`default_nettype none
module amel_checker (
  input wire        clk,
  input wire        rst_n,
  input wire        out_tvalid,
  input wire        out_tready,
  input wire [31:0] out_tdata,
  input wire        out_tlast,
  input wire        out_tuser
);

  // A stalled word keeps its payload.
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata)
      && $stable(out_tlast) && $stable(out_tuser))
    else $error("output word changed while stalled");

  // Edges lie on or above the diagonal.
  a_upper: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[13:7] >= out_tdata[6:0])
    else $error("edge below the diagonal");

  // Vertex numbers are one-based and within the matrix.
  a_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[6:0] != 7'd0 && out_tdata[13:7] <= 7'd64)
    else $error("vertex number out of range");

  // The edge index saturates at the top of the list.
  a_index: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[25:14] <= 12'd2079 && out_tdata[31:26] == 6'd0)
    else $error("edge index beyond the top of the list");

endmodule

bind adjacency_matrix_to_edge_list amel_checker u_amel_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tlast  (out_tlast),
  .out_tuser  (out_tuser)
);
`default_nettype wire
